/* sv/copy_engine_peer_assigner_unit_assert.svh */
// Assertion helpers for the copy engine peer assigner walk module.
// Both expect signals named clk and rst in the enclosing module.
`ifndef COPY_ENGINE_PEER_ASSIGNER_UNIT_ASSERT_SVH
`define COPY_ENGINE_PEER_ASSIGNER_UNIT_ASSERT_SVH

`define CEPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define CEPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cepa_pkg.sv */
package cepa_pkg;

  localparam int MAX_ENGINES_DEF = 16;
  localparam int MAX_PEERS_DEF   = 32;
  localparam int PCE_WIDTH_DEF   = 16;

  localparam int KIND_W     = 2;
  localparam int ENG_IDX_W  = 4;
  localparam int PCE_BITS_W = 16;
  localparam int PEER_W     = 5;
  localparam int LINK_W     = 5;
  localparam int MASK_W     = 16;
  localparam int EC_W       = 5;
  localparam int STUB_W     = 16;
  localparam int PCNT_W     = 6;

  localparam int TD_ENG_LSB    = 0;
  localparam int TD_PCE_LSB    = TD_ENG_LSB + ENG_IDX_W;
  localparam int TD_PEER_LSB   = TD_PCE_LSB + PCE_BITS_W;
  localparam int TD_SINGLE_BIT = TD_PEER_LSB + PEER_W;
  localparam int TD_LINK_LSB   = TD_SINGLE_BIT + 1;
  localparam int S_TDATA_W     = 32;
  localparam int M_TDATA_W     = MASK_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [EC_W-1:0]      ENGINE_COUNT_RST = EC_W'(9);
  localparam logic [ENG_IDX_W-1:0] FIRST_PEER_RST   = ENG_IDX_W'(2);
  localparam logic [ENG_IDX_W-1:0] SYSMEM_ENG_RST   = ENG_IDX_W'(1);
  localparam logic [STUB_W-1:0]    STUBBED_RST      = '0;
  localparam logic                 SWITCH_RST       = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENGINE_COUNT    = 3'd0,
    CFG_FIRST_PEER      = 3'd1,
    CFG_SYSMEM_ENGINE   = 3'd2,
    CFG_STUBBED         = 3'd3,
    CFG_SWITCH_ATTACHED = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [EC_W-1:0]      engine_count;
    logic [ENG_IDX_W-1:0] first_peer_engine;
    logic [ENG_IDX_W-1:0] sysmem_write_engine;
    logic [STUB_W-1:0]    stubbed_engines;
    logic                 switch_attached;
  } cfg_t;

  typedef struct packed {
    logic owner_wr;
    logic owner_clr;
    logic pce_wr;
  } store_ctrl_t;

  function automatic logic [PCNT_W-1:0] popcount32(input logic [31:0] v);
    logic [PCNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < 32; k++) begin
      c = c + PCNT_W'(v[k]);
    end
    return c;
  endfunction

endpackage

/* sv/cepa_store.sv */
module cepa_store import cepa_pkg::*; #(
  parameter int MAX_ENGINES = MAX_ENGINES_DEF,
  parameter int MAX_PEERS   = MAX_PEERS_DEF,
  parameter int PCE_WIDTH   = PCE_WIDTH_DEF,
  localparam int ENG_AW     = $clog2(MAX_ENGINES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  store_ctrl_t           ctrl,
  input  logic [ENG_AW-1:0]     rd_addr,
  input  logic [ENG_AW-1:0]     own_addr,
  input  logic [MAX_PEERS-1:0]  own_wdata,
  input  logic [ENG_AW-1:0]     pce_addr,
  input  logic [PCE_WIDTH-1:0]  pce_wdata,
  output logic [MAX_PEERS-1:0]  own_rdata,
  output logic [PCE_WIDTH-1:0]  pce_rdata
);

  logic [MAX_PEERS-1:0] own_mem [MAX_ENGINES];
  logic [PCE_WIDTH-1:0] pce_mem [MAX_ENGINES];
  logic [MAX_ENGINES-1:0] own_vld;
  logic [MAX_ENGINES-1:0] pce_vld;
  logic [MAX_PEERS-1:0] own_q;
  logic [PCE_WIDTH-1:0] pce_q;
  logic own_vq;
  logic pce_vq;

  // An entry never written since reset (or, for the owner memory, since the last clear) reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_vld <= '0;
      pce_vld <= '0;
    end else begin
      if (ctrl.owner_clr) begin
        own_vld <= '0;
      end else if (ctrl.owner_wr) begin
        own_vld[own_addr] <= 1'b1;
      end
      if (ctrl.pce_wr) begin
        pce_vld[pce_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.owner_wr) begin
      own_mem[own_addr] <= own_wdata;
    end
    if (ctrl.pce_wr) begin
      pce_mem[pce_addr] <= pce_wdata;
    end
    own_q  <= own_mem[rd_addr];
    pce_q  <= pce_mem[rd_addr];
    own_vq <= own_vld[rd_addr];
    pce_vq <= pce_vld[rd_addr];
  end

  assign own_rdata = own_vq ? own_q : '0;
  assign pce_rdata = pce_vq ? pce_q : '0;

endmodule

/* sv/cepa_walk.sv */
module cepa_walk import cepa_pkg::*; #(
  parameter int MAX_ENGINES = MAX_ENGINES_DEF,
  parameter int MAX_PEERS   = MAX_PEERS_DEF,
  parameter int PCE_WIDTH   = PCE_WIDTH_DEF,
  localparam int ENG_AW     = $clog2(MAX_ENGINES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tuser,
  output store_ctrl_t           st_ctrl,
  output logic [ENG_AW-1:0]     rd_addr,
  output logic [ENG_AW-1:0]     own_addr,
  output logic [MAX_PEERS-1:0]  own_wdata,
  output logic [ENG_AW-1:0]     pce_addr,
  output logic [PCE_WIDTH-1:0]  pce_wdata,
  input  logic [MAX_PEERS-1:0]  own_rdata,
  input  logic [PCE_WIDTH-1:0]  pce_rdata
);

  `include "copy_engine_peer_assigner_unit_assert.svh"

  localparam int LIM_W     = $clog2(MAX_ENGINES + 1);
  localparam int IW        = (LIM_W > ENG_IDX_W) ? LIM_W : ENG_IDX_W;
  localparam int PEER_SPAN = 2 ** PEER_W;

  state_t st, st_next;
  logic [IW-1:0] ri, ri_next;
  logic pend, pend_next;
  logic [ENG_AW-1:0] ei, ei_next;
  logic [MAX_PEERS-1:0] pbit, pbit_next;
  logic [LINK_W-1:0] links, links_next;
  logic match_f, match_f_next, match_free, match_free_next;
  logic [ENG_AW-1:0] match_i, match_i_next;
  logic sub_f, sub_f_next;
  logic [ENG_AW-1:0] sub_i, sub_i_next;
  logic max_f, max_f_next, max_free, max_free_next;
  logic [ENG_AW-1:0] max_i, max_i_next;
  logic [PCNT_W-1:0] max_n, max_n_next;
  logic [MASK_W-1:0] res_mask, res_mask_next;
  logic res_ok, res_ok_next;

  kind_t kind;
  logic [ENG_IDX_W-1:0] eng_in;
  logic [PCE_BITS_W-1:0] pce_in;
  logic [PEER_W-1:0] peer_in;
  logic single_in;
  logic [LINK_W-1:0] links_in;
  logic accept;
  logic [LIM_W-1:0] limit;
  logic [MASK_W-1:0] single_mask;
  logic [MAX_PEERS-1:0] pbit_tab [PEER_SPAN];
  logic [MAX_ENGINES-1:0] stub_vec;
  logic issue;
  logic [PCNT_W-1:0] n;
  logic own_zero, hit;
  logic [ENG_AW-1:0] tgt;
  logic found, tgt_free;
  logic out_load;

  for (genvar p = 0; p < PEER_SPAN; p++) begin : g_pbit
    localparam int PM = p % MAX_PEERS;
    assign pbit_tab[p] = MAX_PEERS'(1) << PM;
  end

  assign kind      = kind_t'(s_tuser);
  assign eng_in    = s_tdata[TD_ENG_LSB +: ENG_IDX_W];
  assign pce_in    = s_tdata[TD_PCE_LSB +: PCE_BITS_W];
  assign peer_in   = s_tdata[TD_PEER_LSB +: PEER_W];
  assign single_in = s_tdata[TD_SINGLE_BIT];
  assign links_in  = s_tdata[TD_LINK_LSB +: LINK_W];

  assign s_tready = (st == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (st == S_DONE) && (!m_tvalid || m_tready);

  assign limit = (int'(cfg.engine_count) >= MAX_ENGINES) ? LIM_W'(MAX_ENGINES)
                                                         : LIM_W'(cfg.engine_count);

  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      single_mask[k] = (k == int'(cfg.first_peer_engine)) ||
                       ((k >= int'(cfg.first_peer_engine)) && (k < int'(limit)));
    end
  end

  assign stub_vec  = MAX_ENGINES'(cfg.stubbed_engines);
  assign issue     = (st == S_WALK) && (ri < IW'(limit));
  assign rd_addr   = issue ? ri[ENG_AW-1:0] : '0;
  assign n         = popcount32(32'(pce_rdata));
  assign own_zero  = (own_rdata == '0);
  assign hit       = |(own_rdata & pbit);

  always_comb begin
    found    = 1'b1;
    tgt_free = 1'b0;
    tgt      = max_i;
    if (!cfg.switch_attached && match_f) begin
      tgt      = match_i;
      tgt_free = match_free;
    end else if (!cfg.switch_attached && sub_f) begin
      tgt      = sub_i;
      tgt_free = 1'b1;
    end else if (max_f) begin
      tgt_free = max_free;
    end else begin
      found = 1'b0;
    end
  end

  assign own_addr  = tgt;
  assign own_wdata = pbit;
  assign pce_addr  = ENG_AW'(eng_in);
  assign pce_wdata = PCE_WIDTH'(pce_in);

  always_comb begin
    st_next         = st;
    ri_next         = ri;
    pend_next       = pend;
    ei_next         = ei;
    pbit_next       = pbit;
    links_next      = links;
    match_f_next    = match_f;
    match_free_next = match_free;
    match_i_next    = match_i;
    sub_f_next      = sub_f;
    sub_i_next      = sub_i;
    max_f_next      = max_f;
    max_free_next   = max_free;
    max_i_next      = max_i;
    max_n_next      = max_n;
    res_mask_next   = res_mask;
    res_ok_next     = res_ok;
    st_ctrl         = '0;
    case (st)
      S_IDLE: begin
        if (accept) begin
          pbit_next     = pbit_tab[peer_in];
          links_next    = links_in;
          ri_next       = IW'(cfg.first_peer_engine);
          pend_next     = 1'b0;
          match_f_next  = 1'b0;
          sub_f_next    = 1'b0;
          max_f_next    = 1'b0;
          max_n_next    = '0;
          res_mask_next = '0;
          res_ok_next   = 1'b0;
          st_next       = S_DONE;
          case (kind)
            KIND_ASSIGN: begin
              res_ok_next = 1'b1;
              if (single_in) begin
                res_mask_next = single_mask;
              end else if (links_in == '0) begin
                res_mask_next = MASK_W'(1) << cfg.sysmem_write_engine;
              end else begin
                res_ok_next = 1'b0;
                st_next     = S_WALK;
              end
            end
            KIND_LOAD: begin
              st_ctrl.pce_wr = (int'(eng_in) < MAX_ENGINES);
            end
            KIND_CLEAR: begin
              st_ctrl.owner_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        pend_next = issue;
        if (issue) begin
          ri_next = ri + IW'(1);
          ei_next = ri[ENG_AW-1:0];
        end
        if (!issue) begin
          st_next = S_PICK;
        end
        if (pend && !stub_vec[ei]) begin
          if ((n > max_n) && (cfg.switch_attached || own_zero)) begin
            max_f_next    = 1'b1;
            max_i_next    = ei;
            max_n_next    = n;
            max_free_next = own_zero;
          end
          if (hit) begin
            match_f_next    = 1'b1;
            match_i_next    = ei;
            match_free_next = 1'b0;
            st_next         = S_PICK;
          end else if (!own_zero) begin
            match_f_next = match_f;
          end else if (n == PCNT_W'(links)) begin
            if (!match_f) begin
              match_f_next    = 1'b1;
              match_i_next    = ei;
              match_free_next = 1'b1;
            end
          end else if (n < PCNT_W'(links)) begin
            if (!sub_f) begin
              sub_f_next = 1'b1;
              sub_i_next = ei;
            end
          end
        end
      end
      S_PICK: begin
        st_ctrl.owner_wr = found && tgt_free;
        res_ok_next      = found;
        res_mask_next    = found ? MASK_W'(MAX_ENGINES'(1) << tgt) : '0;
        st_next          = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      pend    <= 1'b0;
      match_f <= 1'b0;
      sub_f   <= 1'b0;
      max_f   <= 1'b0;
      max_n   <= '0;
    end else begin
      st      <= st_next;
      pend    <= pend_next;
      match_f <= match_f_next;
      sub_f   <= sub_f_next;
      max_f   <= max_f_next;
      max_n   <= max_n_next;
    end
  end

  always_ff @(posedge clk) begin
    ri         <= ri_next;
    ei         <= ei_next;
    pbit       <= pbit_next;
    links      <= links_next;
    match_free <= match_free_next;
    match_i    <= match_i_next;
    sub_i      <= sub_i_next;
    max_free   <= max_free_next;
    max_i      <= max_i_next;
    res_mask   <= res_mask_next;
    res_ok     <= res_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_mask;
      m_tuser <= res_ok;
    end
  end

  `CEPA_ASSERT_NEXT(a_busy_after_beat, accept, !s_tready, "input beat taken while busy")
  `CEPA_ASSERT_IMPL(a_mask_needs_grant, m_tvalid && (m_tdata != '0), m_tuser, "mask without grant")
  `CEPA_ASSERT_IMPL(a_max_nonzero, max_f, max_n != '0, "max engine recorded with zero PCEs")
  `CEPA_ASSERT_IMPL(a_owner_wr_pick, st_ctrl.owner_wr, st == S_PICK, "owner write outside pick")

endmodule

/* sv/copy_engine_peer_assigner_unit.sv */
// Flow: a mask load, clear, single-device or no-link request goes from IDLE straight to DONE and
// then to the registered result beat; a walked request passes through WALK, PICK and DONE, and
// WALK reads the engines from first_peer_engine up to engine_count (at most MAX_ENGINES), one per
// cycle from the memories; an engine already owned by the peer ends the walk early.
// Throughput: one item at a time; s_tready stays low until the result beat is loaded.
// Reset (synchronous, rst high) restores the register defaults and empties both memories at once.
module copy_engine_peer_assigner_unit import cepa_pkg::*; #(
  parameter int MAX_ENGINES = MAX_ENGINES_DEF,
  parameter int MAX_PEERS   = MAX_PEERS_DEF,
  parameter int PCE_WIDTH   = PCE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // engine_index, pce_bits, peer_index, single_device, link_count, zero pad
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // kind
  input  logic [KIND_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // engine_mask
  output logic [M_TDATA_W-1:0]   m_tdata,
  // assigned
  output logic                   m_tuser
);

  localparam int ENG_AW = $clog2(MAX_ENGINES);

  cfg_t cfg;
  store_ctrl_t st_ctrl;
  logic [ENG_AW-1:0] rd_addr;
  logic [ENG_AW-1:0] own_addr;
  logic [ENG_AW-1:0] pce_addr;
  logic [MAX_PEERS-1:0] own_wdata;
  logic [MAX_PEERS-1:0] own_rdata;
  logic [PCE_WIDTH-1:0] pce_wdata;
  logic [PCE_WIDTH-1:0] pce_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.engine_count        <= ENGINE_COUNT_RST;
      cfg.first_peer_engine   <= FIRST_PEER_RST;
      cfg.sysmem_write_engine <= SYSMEM_ENG_RST;
      cfg.stubbed_engines     <= STUBBED_RST;
      cfg.switch_attached     <= SWITCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENGINE_COUNT:    cfg.engine_count        <= cfg_data[EC_W-1:0];
        CFG_FIRST_PEER:      cfg.first_peer_engine   <= cfg_data[ENG_IDX_W-1:0];
        CFG_SYSMEM_ENGINE:   cfg.sysmem_write_engine <= cfg_data[ENG_IDX_W-1:0];
        CFG_STUBBED:         cfg.stubbed_engines     <= cfg_data[STUB_W-1:0];
        CFG_SWITCH_ATTACHED: cfg.switch_attached     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cepa_walk #(
    .MAX_ENGINES (MAX_ENGINES),
    .MAX_PEERS   (MAX_PEERS),
    .PCE_WIDTH   (PCE_WIDTH)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .st_ctrl   (st_ctrl),
    .rd_addr   (rd_addr),
    .own_addr  (own_addr),
    .own_wdata (own_wdata),
    .pce_addr  (pce_addr),
    .pce_wdata (pce_wdata),
    .own_rdata (own_rdata),
    .pce_rdata (pce_rdata)
  );

  cepa_store #(
    .MAX_ENGINES (MAX_ENGINES),
    .MAX_PEERS   (MAX_PEERS),
    .PCE_WIDTH   (PCE_WIDTH)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (st_ctrl),
    .rd_addr   (rd_addr),
    .own_addr  (own_addr),
    .own_wdata (own_wdata),
    .pce_addr  (pce_addr),
    .pce_wdata (pce_wdata),
    .own_rdata (own_rdata),
    .pce_rdata (pce_rdata)
  );

endmodule
